// File: hdl/sdw_pkg.sv
`timescale 1ns / 1ps

package sdw_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int FRAC_W    = 20;
  localparam int ADDR_W    = 17;
  localparam int STORE_W   = 2 * SAMPLE_W;
  localparam int EXP_AW    = 10;
  localparam int EXP_DEPTH = 1 << EXP_AW;
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;

  // x / 100 == (x * RECIP_100) >> RECIP_100_SH for x < 2^33
  localparam logic [32:0] RECIP_100    = 33'd5497558139;
  localparam int          RECIP_100_SH = 39;
  // x / 6 == (x * RECIP_6) >> RECIP_6_SH for x < 2^22
  localparam logic [21:0] RECIP_6      = 22'd2796203;
  localparam int          RECIP_6_SH   = 24;

  localparam logic [2:0] SHAPE_BYPASS = 3'd0;
  localparam logic [2:0] SHAPE_HARD   = 3'd1;
  localparam logic [2:0] SHAPE_CUBIC  = 3'd2;
  localparam logic [2:0] SHAPE_EXP    = 3'd3;
  localparam logic [2:0] SHAPE_FULL   = 3'd4;
  localparam logic [2:0] SHAPE_HALF   = 3'd5;

  localparam logic [2:0] REG_DELAY    = 3'd0;
  localparam logic [2:0] REG_IN_GAIN  = 3'd1;
  localparam logic [2:0] REG_OUT_LVL  = 3'd2;
  localparam logic [2:0] REG_SHAPE    = 3'd3;
  localparam logic [2:0] REG_WET_ONLY = 3'd4;
  localparam logic [2:0] REG_DRY_MIX  = 3'd5;
  localparam logic [2:0] REG_WET_MIX  = 3'd6;
  localparam logic [2:0] REG_FEEDBACK = 3'd7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [FRAC_W:0] exp_word_t;
  typedef exp_word_t exp_tab_t [EXP_DEPTH];

  typedef struct packed {
    logic [ADDR_W-1:0] delay_samples;
    logic [15:0]       input_gain;
    logic [15:0]       output_level;
    logic [2:0]        shape_mode;
    logic              wet_only;
    logic [6:0]        dry_mix;
    logic [6:0]        wet_mix;
    logic [6:0]        feedback_pct;
  } sdw_cfg_t;

  function automatic sample_t sat(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return sample_t'(hi);
    if (v < lo) return sample_t'(lo);
    return sample_t'(v);
  endfunction

  // 1 - exp(-8 i / EXP_DEPTH) in Q20, from a series for exp(-f) raised to the 8th power
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t           tab;
    logic [63:0]        f;
    logic [63:0]        t;
    logic [63:0]        s;
    logic signed [63:0] sum;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      f   = 64'(i) << (20 - EXP_AW);
      t   = 64'd1 << 40;
      sum = 64'sd1 <<< 40;
      for (int n = 1; n <= 24; n++) begin
        t = ((t * f) >> 20) / 64'(n);
        if (n[0]) sum = sum - $signed(t);
        else sum = sum + $signed(t);
      end
      s = $unsigned(sum) >> 10;
      for (int k = 0; k < 3; k++) s = (s * s) >> 30;
      tab[i] = exp_word_t'((64'd1 << FRAC_W) - ((s + 64'd512) >> 10));
    end
    return tab;
  endfunction

endpackage

// File: hdl/sdw_ram.sv
`timescale 1ns / 1ps

module sdw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sdw_exp_rom.sv
`timescale 1ns / 1ps

module sdw_exp_rom (
  input  logic                      clk,
  input  logic [sdw_pkg::EXP_AW-1:0] addr,
  output sdw_pkg::exp_word_t        data
);
  import sdw_pkg::*;

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  always_ff @(posedge clk) begin
    data <= EXP_TAB[addr];
  end

endmodule

// File: hdl/sdw_mult.sv
`timescale 1ns / 1ps

module sdw_mult (
  input  logic                              clk,
  input  logic signed [sdw_pkg::MUL_W-1:0]  a,
  input  logic signed [sdw_pkg::MUL_W-1:0]  b,
  output logic signed [sdw_pkg::PROD_W-1:0] p
);
  import sdw_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: hdl/sdw_core.sv
`timescale 1ns / 1ps

module sdw_core (
  input  logic                          clk,
  input  logic                          rst,
  input  sdw_pkg::sdw_cfg_t             cfg,
  input  logic                          start,
  input  sdw_pkg::sample_t              in_l,
  input  sdw_pkg::sample_t              in_r,
  output logic                          idle,
  output logic                          done,
  input  logic                          take,
  output sdw_pkg::sample_t              res_l,
  output sdw_pkg::sample_t              res_r,
  output logic [sdw_pkg::ADDR_W-1:0]    rd_addr,
  input  logic [sdw_pkg::STORE_W-1:0]   rd_data,
  output logic                          wr_en,
  output logic [sdw_pkg::ADDR_W-1:0]    wr_addr,
  output logic [sdw_pkg::STORE_W-1:0]   wr_data
);
  import sdw_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_G    = 4'd2;
  localparam logic [3:0] ST_SH   = 4'd3;
  localparam logic [3:0] ST_C2   = 4'd4;
  localparam logic [3:0] ST_C3   = 4'd5;
  localparam logic [3:0] ST_LV   = 4'd6;
  localparam logic [3:0] ST_W    = 4'd7;
  localparam logic [3:0] ST_D    = 4'd8;
  localparam logic [3:0] ST_Q    = 4'd9;
  localparam logic [3:0] ST_F    = 4'd10;
  localparam logic [3:0] ST_FQ   = 4'd11;
  localparam logic [3:0] ST_WBR  = 4'd12;
  localparam logic [3:0] ST_WBW  = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  localparam int XG_W = SAMPLE_W + 4;
  localparam int X3_W = XG_W + 2;
  localparam int Y_W  = XG_W + 1;
  localparam logic signed [X3_W-1:0] ONE_Q  = X3_W'(1 << FRAC_W);
  localparam logic signed [X3_W-1:0] TWO_Q  = X3_W'(2 << FRAC_W);
  localparam logic signed [Y_W-1:0]  HALF_Y = Y_W'(1 << (FRAC_W - 1));
  localparam logic signed [Y_W-1:0]  ONE_Y  = Y_W'(1 << FRAC_W);
  localparam logic [63:0]            THREE_Q2 = 64'd3 << (2 * FRAC_W);

  logic [3:0]              state;
  logic                    ch;
  logic [ADDR_W-1:0]       wr_idx;
  logic [ADDR_W-1:0]       ra;
  sample_t                 x_in;
  sample_t                 s_cur;
  sample_t                 wet_cur;
  sample_t                 wet0, wet1, st0, st1;
  logic signed [XG_W-1:0]  xg;
  logic                    cub_hi, cub_lo, cub_pm, cub_nm;
  logic                    exp_big;
  logic [EXP_AW-1:0]       erom_addr;
  exp_word_t               erom_data;
  logic                    sgn;
  logic signed [32:0]      acc;
  logic signed [MUL_W-1:0] ma, mb;
  logic signed [PROD_W-1:0] p;

  // combinational helpers
  logic signed [XG_W-1:0]  xg_n;
  logic signed [X3_W-1:0]  x3_n;
  logic signed [X3_W-1:0]  u_full;
  logic [XG_W:0]           mag_n;
  logic [63:0]             cub_num;
  logic [FRAC_W:0]         q6;
  logic signed [Y_W-1:0]   shaped;
  logic signed [Y_W-1:0]   exp_y;
  sample_t                 wet_n;
  logic signed [32:0]      acc_sum;
  logic [32:0]             acc_mag;
  logic [25:0]             q100;
  logic signed [33:0]      q100_s;

  sdw_mult u_mult (.clk(clk), .a(ma), .b(mb), .p(p));
  sdw_exp_rom u_rom (.clk(clk), .addr(erom_addr), .data(erom_data));

  assign s_cur   = ch ? sample_t'(rd_data[STORE_W-1:SAMPLE_W]) : sample_t'(rd_data[SAMPLE_W-1:0]);
  assign x_in    = ch ? in_r : in_l;
  assign wet_cur = ch ? wet1 : wet0;

  assign xg_n   = p[XG_W+11:12];
  assign x3_n   = X3_W'(xg_n) + X3_W'(xg_n) + X3_W'(xg_n);
  assign u_full = (x3_n > 0) ? TWO_Q - x3_n : TWO_Q + x3_n;
  assign mag_n  = xg_n[XG_W-1] ? (XG_W+1)'(-$signed((XG_W+1)'(xg_n)))
                               : (XG_W+1)'(xg_n);
  assign cub_num = THREE_Q2 - 64'(p[2*FRAC_W+1:0]);
  assign q6      = p[RECIP_6_SH+FRAC_W:RECIP_6_SH];
  assign exp_y   = exp_big ? ONE_Y : Y_W'(erom_data);

  always_comb begin
    case (cfg.shape_mode)
      SHAPE_HARD: begin
        if (Y_W'(xg) > HALF_Y) shaped = HALF_Y;
        else if (Y_W'(xg) < -HALF_Y) shaped = -HALF_Y;
        else shaped = Y_W'(xg);
      end
      SHAPE_CUBIC: begin
        if (cub_hi) shaped = HALF_Y;
        else if (cub_lo) shaped = -HALF_Y;
        else if (cub_pm) shaped = Y_W'(q6);
        else if (cub_nm) shaped = -Y_W'(q6);
        else shaped = Y_W'(xg);
      end
      SHAPE_EXP:  shaped = (xg > 0) ? exp_y : -exp_y;
      SHAPE_FULL: shaped = xg[XG_W-1] ? -Y_W'(xg) : Y_W'(xg);
      SHAPE_HALF: shaped = xg[XG_W-1] ? '0 : Y_W'(xg);
      default:    shaped = Y_W'(xg);
    endcase
  end

  assign wet_n   = (cfg.shape_mode == SHAPE_BYPASS) ? s_cur : sat(64'(p >>> 12));
  // wet_only drops only the dry product; the feedback product in ST_F always passes
  assign acc_sum = acc + ((cfg.wet_only && (state == ST_D)) ? 33'sd0 : p[32:0]);
  assign acc_mag = acc_sum[32] ? 33'(-acc_sum) : 33'(acc_sum);
  assign q100    = p[RECIP_100_SH+25:RECIP_100_SH];
  assign q100_s  = sgn ? -34'(q100) : 34'(q100);

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_G: begin
        ma = MUL_W'(s_cur);
        mb = MUL_W'(cfg.input_gain);
      end
      ST_SH: begin
        ma = MUL_W'(u_full[FRAC_W:0]);
        mb = MUL_W'(u_full[FRAC_W:0]);
      end
      ST_C2: begin
        ma = MUL_W'(cub_num[2*FRAC_W+1:FRAC_W]);
        mb = MUL_W'(RECIP_6);
      end
      ST_C3: begin
        ma = MUL_W'(shaped);
        mb = MUL_W'(cfg.output_level);
      end
      ST_LV: begin
        ma = MUL_W'(wet_n);
        mb = MUL_W'(cfg.wet_mix);
      end
      ST_W: begin
        ma = MUL_W'(x_in);
        mb = MUL_W'(cfg.dry_mix);
      end
      ST_D: begin
        ma = MUL_W'(acc_mag);
        mb = MUL_W'(RECIP_100);
      end
      ST_Q: begin
        ma = MUL_W'(wet_cur);
        mb = MUL_W'(cfg.feedback_pct);
      end
      ST_F: begin
        ma = MUL_W'(acc_mag);
        mb = MUL_W'(RECIP_100);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ch     <= 1'b0;
      wr_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: if (start) begin
          ra    <= wr_idx - cfg.delay_samples;
          ch    <= 1'b0;
          state <= ST_READ;
        end
        ST_READ: state <= ST_G;
        ST_G:    state <= ST_SH;
        ST_SH: begin
          xg        <= xg_n;
          cub_hi    <= x3_n > TWO_Q;
          cub_lo    <= x3_n < -TWO_Q;
          cub_pm    <= x3_n > ONE_Q;
          cub_nm    <= x3_n < -ONE_Q;
          exp_big   <= |mag_n[XG_W:FRAC_W+3];
          erom_addr <= mag_n[FRAC_W+2:FRAC_W+3-EXP_AW];
          state     <= ST_C2;
        end
        ST_C2: state <= ST_C3;
        ST_C3: state <= ST_LV;
        ST_LV: begin
          if (ch) wet1 <= wet_n;
          else wet0 <= wet_n;
          state <= ST_W;
        end
        ST_W: begin
          acc   <= p[32:0];
          state <= ST_D;
        end
        ST_D: begin
          sgn   <= acc_sum[32];
          state <= ST_Q;
        end
        ST_Q: begin
          if (ch) res_r <= sat(64'(q100_s));
          else res_l <= sat(64'(q100_s));
          acc   <= '0;
          state <= ST_F;
        end
        ST_F: begin
          // acc is zero here, so acc_sum carries the feedback product
          sgn   <= acc_sum[32];
          state <= ST_FQ;
        end
        ST_FQ: begin
          if (ch) st1 <= sat(64'(x_in) + 64'(q100_s));
          else st0 <= sat(64'(x_in) + 64'(q100_s));
          if (ch) begin
            state <= ST_WBR;
          end else begin
            ch    <= 1'b1;
            state <= ST_G;
          end
        end
        ST_WBR: state <= ST_WBW;
        ST_WBW: begin
          wr_idx <= wr_idx + 1'b1;
          state  <= ST_DONE;
        end
        ST_DONE: if (take) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign idle    = (state == ST_IDLE);
  assign done    = (state == ST_DONE);
  assign rd_addr = ra;
  // read slot first, then write slot, so the feedback write wins at zero delay
  assign wr_en   = (state == ST_WBR) || (state == ST_WBW);
  assign wr_addr = (state == ST_WBR) ? ra : wr_idx;
  assign wr_data = (state == ST_WBR) ? {wet1, wet0} : {st1, st0};

endmodule

// File: hdl/stereo_delay_waveshaper.sv
`timescale 1ns / 1ps

// Stereo delay with waveshaping on the delayed path. A frame (left_in, right_in) is
// taken on in_valid/in_ready; each channel's delayed sample is gained, shaped, leveled,
// mixed with the dry input and written back with feedback into a 131072-frame store.
// All arithmetic runs through one 34x34 multiplier under a state sequencer, nine
// multiplier steps per channel; a finished frame waits until the output register can
// take it, and the next frame is accepted as soon as the sequencer is back to idle.
// After reset the store is cleared one frame per cycle, during which no frame is
// accepted; the APB registers can be written at any time the datapath is idle.
module stereo_delay_waveshaper (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [23:0]      left_in,
  input  logic signed [23:0]      right_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [23:0]      left_out,
  output logic signed [23:0]      right_out
);
  import sdw_pkg::*;

  sdw_cfg_t            cfg;
  logic                clearing;
  logic [ADDR_W-1:0]   clr_addr;
  logic                core_idle, core_done, take;
  sample_t             res_l, res_r;
  sample_t             in_l_q, in_r_q;
  logic [ADDR_W-1:0]   rd_addr, core_waddr, ram_waddr;
  logic [STORE_W-1:0]  rd_data, core_wdata, ram_wdata;
  logic                core_we, ram_we;
  logic                wr_hit;
  logic                start;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_samples <= ADDR_W'(24000);
      cfg.input_gain    <= 16'd4096;
      cfg.output_level  <= 16'd4096;
      cfg.shape_mode    <= SHAPE_HARD;
      cfg.wet_only      <= 1'b0;
      cfg.dry_mix       <= 7'd100;
      cfg.wet_mix       <= 7'd0;
      cfg.feedback_pct  <= 7'd0;
    end else if (wr_hit) begin
      case (paddr[4:2])
        REG_DELAY:    cfg.delay_samples <= pwdata[ADDR_W-1:0];
        REG_IN_GAIN:  cfg.input_gain    <= pwdata[15:0];
        REG_OUT_LVL:  cfg.output_level  <= pwdata[15:0];
        REG_SHAPE:    cfg.shape_mode    <= pwdata[2:0];
        REG_WET_ONLY: cfg.wet_only      <= pwdata[0];
        REG_DRY_MIX:  cfg.dry_mix       <= pwdata[6:0];
        REG_WET_MIX:  cfg.wet_mix       <= pwdata[6:0];
        REG_FEEDBACK: cfg.feedback_pct  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DELAY:    prdata = 32'(cfg.delay_samples);
      REG_IN_GAIN:  prdata = 32'(cfg.input_gain);
      REG_OUT_LVL:  prdata = 32'(cfg.output_level);
      REG_SHAPE:    prdata = 32'(cfg.shape_mode);
      REG_WET_ONLY: prdata = 32'(cfg.wet_only);
      REG_DRY_MIX:  prdata = 32'(cfg.dry_mix);
      REG_WET_MIX:  prdata = 32'(cfg.wet_mix);
      REG_FEEDBACK: prdata = 32'(cfg.feedback_pct);
      default:      prdata = '0;
    endcase
  end

  // store clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) clearing <= 1'b0;
    end
  end

  assign in_ready = core_idle && !clearing;
  assign start    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (start) begin
      in_l_q <= left_in;
      in_r_q <= right_in;
    end
  end

  sdw_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start),
    .in_l(start ? left_in : in_l_q), .in_r(start ? right_in : in_r_q),
    .idle(core_idle), .done(core_done), .take(take),
    .res_l(res_l), .res_r(res_r),
    .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(core_we), .wr_addr(core_waddr), .wr_data(core_wdata)
  );

  assign ram_we    = clearing || core_we;
  assign ram_waddr = clearing ? clr_addr : core_waddr;
  assign ram_wdata = clearing ? '0 : core_wdata;

  sdw_ram #(.WIDTH(STORE_W), .DEPTH(1 << ADDR_W)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(rd_addr), .rdata(rd_data)
  );

  // output register: a finished frame moves in once the previous one is gone
  assign take = core_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_out  <= res_l;
      right_out <= res_r;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready) else $error("frame accepted during store clear");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready) else $error("second frame accepted while busy");

  a_take_loads_output: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid) else $error("finished frame not presented");

  a_no_store_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    core_idle |-> !core_we) else $error("store written by idle sequencer");

endmodule
